// ----- design/mlp_pkg.sv -----
// ----------------------------------------------------------------------------
// mlp_pkg
// Shared constants, codes, control structs and helpers for the MLP inference
// block.
// ----------------------------------------------------------------------------
package mlp_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_LAYERS   = 4;
	localparam int WEIGHT_WORDS = 131072;
	localparam int VALUE_BITS   = 16;
	localparam int FRAC_BITS    = 11;
	localparam int ACC_BITS     = 48;

	localparam int IDX_BITS   = 10;
	localparam int SIZE_BITS  = 11;
	localparam int LAYER_BITS = 2;
	localparam int CNT_BITS   = 3;
	localparam int WADDR_BITS = 17;
	localparam int WCNT_BITS  = 23;
	localparam int BIAS_DEPTH = MAX_LAYERS * MAX_WIDTH;
	localparam int ACT_DEPTH  = 2 * MAX_WIDTH;
	localparam int SCORE_BITS = VALUE_BITS - 1;
	localparam int CFG_BITS   = 11;
	localparam int CFG_IDX_BITS = 3;
	localparam int SETTLE_CYCLES = 2;

	localparam logic [1:0] FUNC_WEIGHT = 2'd0;
	localparam logic [1:0] FUNC_BIAS   = 2'd1;
	localparam logic [1:0] FUNC_PIXEL  = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_LAYER_COUNT = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_SIZE  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LAYER1_SIZE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LAYER2_SIZE = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LAYER3_SIZE = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LAYER4_SIZE = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LD_WR,
		ST_ROW_BIAS,
		ST_MAC,
		ST_DRAIN,
		ST_WRITE,
		ST_FINISH
	} mlp_state_t;

	typedef struct packed {
		logic take;
		logic ld_mul;
		logic wr_weight;
		logic wr_bias;
		logic wr_pixel;
		logic inf_init;
		logic row_start;
		logic mac;
		logic row_write;
		logic finish;
	} mlp_cmd_t;

	typedef struct packed {
		logic       item_valid;
		logic [1:0] func;
		logic       last;
		logic       c_last;
		logic       r_last;
		logic       layer_last;
		logic       pipe_busy;
		logic       res_free;
	} mlp_stat_t;

	function automatic logic [SIZE_BITS-1:0] size_clip(input logic [SIZE_BITS-1:0] v);
		logic [SIZE_BITS-1:0] r;
		if (v == '0)
			r = SIZE_BITS'(1);
		else if (v > SIZE_BITS'(MAX_WIDTH))
			r = SIZE_BITS'(MAX_WIDTH);
		else
			r = v;
		return r;
	endfunction

	function automatic logic [CNT_BITS-1:0] count_clip(input logic [CNT_BITS-1:0] v);
		logic [CNT_BITS-1:0] r;
		if (v == '0)
			r = CNT_BITS'(1);
		else if (v > CNT_BITS'(MAX_LAYERS))
			r = CNT_BITS'(MAX_LAYERS);
		else
			r = v;
		return r;
	endfunction

	// ReLU, round half up to Q4.11, saturate
	function automatic logic [SCORE_BITS-1:0] narrow_relu(input logic signed [ACC_BITS-1:0] a);
		logic signed [ACC_BITS:0]           t;
		logic signed [ACC_BITS-FRAC_BITS:0] q;
		logic [SCORE_BITS-1:0]              r;
		t = {a[ACC_BITS-1], a} + (ACC_BITS+1)'(1 << (FRAC_BITS - 1));
		q = t[ACC_BITS:FRAC_BITS];
		if (a <= 0)
			r = '0;
		else if (q > (ACC_BITS-FRAC_BITS+1)'((1 << SCORE_BITS) - 1))
			r = '1;
		else
			r = q[SCORE_BITS-1:0];
		return r;
	endfunction

endpackage

// ----- design/mlp_in_if.sv -----
// ----------------------------------------------------------------------------
// mlp_in_if
// Input item channel: valid/ready handshake with load and pixel payload.
// ----------------------------------------------------------------------------
interface mlp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [1:0]  layer_index;
	logic [9:0]  row_index;
	logic [9:0]  col_index;
	logic signed [15:0] item_value;
	logic [9:0]  sample_label;
	logic        last_pixel;

	modport source (output valid, func, layer_index, row_index, col_index, item_value,
		sample_label, last_pixel, input ready);
	modport sink (input valid, func, layer_index, row_index, col_index, item_value,
		sample_label, last_pixel, output ready);
endinterface

// ----- design/mlp_out_if.sv -----
// ----------------------------------------------------------------------------
// mlp_out_if
// Result channel: valid/ready handshake with classification payload.
// ----------------------------------------------------------------------------
interface mlp_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  predicted_class;
	logic [14:0] max_score;
	logic        matches_label;

	modport source (output valid, predicted_class, max_score, matches_label, input ready);
	modport sink (input valid, predicted_class, max_score, matches_label, output ready);
endinterface

// ----- design/mlp_ram.sv -----
// ----------------------------------------------------------------------------
// mlp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mlp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- design/mlp_datapath.sv -----
// ----------------------------------------------------------------------------
// mlp_datapath
// Config registers, weight/bias/activation stores, MAC pipeline, narrowing,
// argmax and the result register.
// ----------------------------------------------------------------------------
module mlp_datapath import mlp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	mlp_in_if.sink                  item,
	mlp_out_if.source               result,
	input  logic                    wr_en,
	input  logic [CFG_IDX_BITS-1:0] wr_index,
	input  logic [CFG_BITS-1:0]     wr_data,
	input  mlp_cmd_t                cmd,
	output mlp_stat_t               st
);

	logic [CNT_BITS-1:0]  layer_count_q;
	logic [SIZE_BITS-1:0] size_q [MAX_LAYERS+1];
	logic [SIZE_BITS-1:0] sz [MAX_LAYERS+1];
	logic [CNT_BITS-1:0]  cnt;
	logic [2*SIZE_BITS-1:0] prod_q [MAX_LAYERS];
	logic [WCNT_BITS-1:0]   base_q [MAX_LAYERS];
	logic [WCNT_BITS-1:0]   base_d [MAX_LAYERS];
	logic [WCNT_BITS-1:0]   base_sum;

	logic [1:0]            func_q;
	logic [LAYER_BITS-1:0] lidx_q;
	logic [IDX_BITS-1:0]   row_q;
	logic [IDX_BITS-1:0]   col_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [IDX_BITS-1:0]   label_q;
	logic                  last_q;

	logic [IDX_BITS+SIZE_BITS-1:0] ld_prod_q;
	logic                          ld_ok_q;
	logic [WCNT_BITS:0]            ld_addr;
	logic                          w_we;

	logic [LAYER_BITS-1:0] layer_q;
	logic [IDX_BITS-1:0]   r_q;
	logic [IDX_BITS-1:0]   c_q;
	logic [WCNT_BITS-1:0]  wcnt_q;
	logic [SIZE_BITS-1:0]  n_in;
	logic [SIZE_BITS-1:0]  n_out;

	logic [VALUE_BITS-1:0] w_rdata, b_rdata, x_rdata, a_rdata;
	logic                  oob_s1, v_s1, bias_s1, l0_s1;
	logic                  v_s2;
	logic signed [2*VALUE_BITS-1:0] prod_s2;
	logic signed [VALUE_BITS-1:0]   w_eff, a_eff;
	logic signed [ACC_BITS-1:0]     acc_q;
	logic [SCORE_BITS-1:0]          narrowed;

	logic [SCORE_BITS-1:0] best_q;
	logic [IDX_BITS-1:0]   best_idx_q;
	logic                  res_valid_q;
	logic [IDX_BITS-1:0]   res_class_q;
	logic [SCORE_BITS-1:0] res_score_q;
	logic                  res_match_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_count_q <= CNT_BITS'(2);
			size_q[0]     <= SIZE_BITS'(784);
			size_q[1]     <= SIZE_BITS'(128);
			size_q[2]     <= SIZE_BITS'(10);
			size_q[3]     <= SIZE_BITS'(10);
			size_q[4]     <= SIZE_BITS'(10);
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_LAYER_COUNT: layer_count_q <= wr_data[CNT_BITS-1:0];
				CFG_INPUT_SIZE:  size_q[0] <= wr_data;
				CFG_LAYER1_SIZE: size_q[1] <= wr_data;
				CFG_LAYER2_SIZE: size_q[2] <= wr_data;
				CFG_LAYER3_SIZE: size_q[3] <= wr_data;
				CFG_LAYER4_SIZE: size_q[4] <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k <= MAX_LAYERS; k++)
			sz[k] = size_clip(size_q[k]);
		cnt = count_clip(layer_count_q);
	end

	// running base addresses over the layer block sizes
	always_comb begin
		base_sum = '0;
		for (int l = 0; l < MAX_LAYERS; l++) begin
			base_d[l] = base_sum;
			base_sum  = base_sum + WCNT_BITS'(prod_q[l]);
		end
	end

	// layer block sizes, then running base addresses
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_LAYERS; k++)
			prod_q[k] <= sz[k] * sz[k+1];
		for (int l = 0; l < MAX_LAYERS; l++)
			base_q[l] <= base_d[l];
	end

	// item capture
	assign item.ready = cmd.take;

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			func_q  <= item.func;
			lidx_q  <= item.layer_index;
			row_q   <= item.row_index;
			col_q   <= item.col_index;
			val_q   <= item.item_value;
			label_q <= item.sample_label;
			last_q  <= item.last_pixel;
		end
	end

	// weight load address
	always_ff @(posedge clk) begin
		if (cmd.ld_mul) begin
			ld_prod_q <= row_q * sz[CNT_BITS'(lidx_q)];
			ld_ok_q   <= (SIZE_BITS'(row_q) < sz[CNT_BITS'(lidx_q) + CNT_BITS'(1)]) &&
				(SIZE_BITS'(col_q) < sz[CNT_BITS'(lidx_q)]);
		end
	end

	assign ld_addr = (WCNT_BITS+1)'(base_q[lidx_q]) + (WCNT_BITS+1)'(ld_prod_q) +
		(WCNT_BITS+1)'(col_q);
	assign w_we = cmd.wr_weight && ld_ok_q && (ld_addr < (WCNT_BITS+1)'(WEIGHT_WORDS));

	// inference counters
	assign n_in  = sz[CNT_BITS'(layer_q)];
	assign n_out = sz[CNT_BITS'(layer_q) + CNT_BITS'(1)];

	always_ff @(posedge clk) begin
		if (cmd.inf_init) begin
			layer_q <= '0;
			r_q     <= '0;
			wcnt_q  <= '0;
		end else if (cmd.row_write) begin
			if (st.r_last) begin
				r_q     <= '0;
				layer_q <= layer_q + LAYER_BITS'(1);
			end else begin
				r_q <= r_q + IDX_BITS'(1);
			end
		end else if (cmd.mac) begin
			wcnt_q <= wcnt_q + WCNT_BITS'(1);
		end
		if (cmd.row_start)
			c_q <= '0;
		else if (cmd.mac)
			c_q <= c_q + IDX_BITS'(1);
	end

	mlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(WEIGHT_WORDS)) u_weight (
		.clk(clk), .we(w_we), .waddr(ld_addr[WADDR_BITS-1:0]), .wdata(val_q),
		.raddr(wcnt_q[WADDR_BITS-1:0]), .rdata(w_rdata)
	);

	mlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(BIAS_DEPTH)) u_bias (
		.clk(clk),
		.we(cmd.wr_bias && (SIZE_BITS'(row_q) < sz[CNT_BITS'(lidx_q) + CNT_BITS'(1)])),
		.waddr({lidx_q, row_q}), .wdata(val_q),
		.raddr({layer_q, r_q}), .rdata(b_rdata)
	);

	mlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_input (
		.clk(clk), .we(cmd.wr_pixel), .waddr(col_q), .wdata(val_q),
		.raddr(c_q), .rdata(x_rdata)
	);

	mlp_ram #(.WIDTH(VALUE_BITS), .DEPTH(ACT_DEPTH)) u_act (
		.clk(clk), .we(cmd.row_write), .waddr({layer_q[0], r_q}),
		.wdata({1'b0, narrowed}),
		.raddr({~layer_q[0], c_q}), .rdata(a_rdata)
	);

	// MAC pipeline: read, multiply, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			bias_s1 <= 1'b0;
		end else begin
			v_s1    <= cmd.mac;
			v_s2    <= v_s1;
			bias_s1 <= cmd.row_start;
		end
	end

	always_ff @(posedge clk) begin
		oob_s1  <= wcnt_q >= WCNT_BITS'(WEIGHT_WORDS);
		l0_s1   <= layer_q == '0;
		prod_s2 <= w_eff * a_eff;
	end

	assign w_eff = oob_s1 ? '0 : $signed(w_rdata);
	assign a_eff = l0_s1 ? $signed(x_rdata) : $signed(a_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_q <= '0;
		else if (bias_s1)
			acc_q <= ACC_BITS'($signed(b_rdata)) <<< FRAC_BITS;
		else if (v_s2)
			acc_q <= acc_q + ACC_BITS'(prod_s2);
	end

	assign narrowed = narrow_relu(acc_q);

	// argmax over the final layer, strict compare keeps the lowest index
	always_ff @(posedge clk) begin
		if (cmd.row_write && st.layer_last && (r_q == '0 || narrowed > best_q)) begin
			best_q     <= narrowed;
			best_idx_q <= r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.finish)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_class_q <= best_idx_q;
			res_score_q <= best_q;
			res_match_q <= best_idx_q == label_q;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.predicted_class = res_class_q;
	assign result.max_score       = res_score_q;
	assign result.matches_label   = res_match_q;

	always_comb begin
		st.item_valid = item.valid;
		st.func       = func_q;
		st.last       = last_q;
		st.c_last     = SIZE_BITS'(c_q) == n_in - SIZE_BITS'(1);
		st.r_last     = SIZE_BITS'(r_q) == n_out - SIZE_BITS'(1);
		st.layer_last = CNT_BITS'(layer_q) == cnt - CNT_BITS'(1);
		st.pipe_busy  = v_s1 | v_s2;
		st.res_free   = !res_valid_q || result.ready;
	end

endmodule

// ----- design/mlp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mlp_ctrl
// Sequencer: decodes items, steps rows and layers, drains the MAC pipeline.
// ----------------------------------------------------------------------------
module mlp_ctrl import mlp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  mlp_stat_t st,
	output mlp_cmd_t  cmd
);

	mlp_state_t state_q, state_d;
	logic [1:0] settle_q;

	// hold off items until base addresses follow a config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			settle_q <= 2'(SETTLE_CYCLES);
		else if (wr_en)
			settle_q <= 2'(SETTLE_CYCLES);
		else if (settle_q != '0)
			settle_q <= settle_q - 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = settle_q == '0;
				if (cmd.take && st.item_valid)
					state_d = ST_DECODE;
			end
			ST_DECODE: begin
				cmd.ld_mul = 1'b1;
				unique case (st.func)
					FUNC_WEIGHT: state_d = ST_LD_WR;
					FUNC_BIAS: begin
						cmd.wr_bias = 1'b1;
						state_d     = ST_IDLE;
					end
					FUNC_PIXEL: begin
						cmd.wr_pixel = 1'b1;
						if (st.last) begin
							cmd.inf_init = 1'b1;
							state_d      = ST_ROW_BIAS;
						end else begin
							state_d = ST_IDLE;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_LD_WR: begin
				cmd.wr_weight = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_ROW_BIAS: begin
				cmd.row_start = 1'b1;
				state_d       = ST_MAC;
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
				if (st.c_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!st.pipe_busy)
					state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.row_write = 1'b1;
				if (st.r_last && st.layer_last)
					state_d = ST_FINISH;
				else
					state_d = ST_ROW_BIAS;
			end
			ST_FINISH: begin
				if (st.res_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- design/mlp_relu_inference_argmax_top.sv -----
// Each weight, bias or plain pixel item is finished before the next item is taken.
// A last pixel runs the whole network, row by row and layer by layer, on the single
// multiply-accumulate unit fed from one weight RAM read port.
// The result waits in an output register; loading resumes while it waits, and
// the next result stalls until that register frees. Reset (arst_n, async low)
// restores config defaults and clears control; stores are not cleared.
// ----------------------------------------------------------------------------
// mlp_relu_inference_argmax_top
// Fully connected ReLU network inference with argmax classification.
// ----------------------------------------------------------------------------
module mlp_relu_inference_argmax_top import mlp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	mlp_in_if.sink                  item,
	mlp_out_if.source               result,
	input  logic                    wr_en,
	input  logic [CFG_IDX_BITS-1:0] wr_index,
	input  logic [CFG_BITS-1:0]     wr_data
);

	mlp_cmd_t  cmd;
	mlp_stat_t st;

	mlp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .st(st), .cmd(cmd)
	);

	mlp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.cmd(cmd), .st(st)
	);

endmodule

// ----- design/mlp_checker.sv -----
// ----------------------------------------------------------------------------
// mlp_checker
// Port-level checks on the inference block, bound to the top level.
// ----------------------------------------------------------------------------
module mlp_checker import mlp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [1:0]  item_func,
	input logic        item_last,
	input logic        res_valid,
	input logic        res_ready,
	input logic [9:0]  res_class,
	input logic [14:0] res_score,
	input logic        res_match,
	input logic        wr_en
);

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_class) &&
		$stable(res_score) && $stable(res_match))
		else $error("result beat changed while stalled");

	// an accepted last pixel starts work, so no item is taken next cycle
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_func == FUNC_PIXEL && item_last |=> !item_ready)
		else $error("item taken right after a last pixel");

	// config write holds off items while bases settle
	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> !item_ready)
		else $error("item taken right after a config write");

	// a new result only appears at the end of inference, while items are held
	a_res_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!item_ready))
		else $error("result appeared without inference");

endmodule

bind mlp_relu_inference_argmax_top mlp_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.item_valid(item.valid), .item_ready(item.ready),
	.item_func(item.func), .item_last(item.last_pixel),
	.res_valid(result.valid), .res_ready(result.ready),
	.res_class(result.predicted_class), .res_score(result.max_score),
	.res_match(result.matches_label), .wr_en(wr_en)
);

// ----- bench/mlp_relu_inference_argmax_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_relu_inference_argmax_top_tb
// Self-checking bench for the MLP inference block. A directed table covers the
// arithmetic corners on a one-neuron net, with expected results in the table;
// several network shapes are then loaded in full and run on random samples,
// checked against a bit-accurate in-bench predictor under random gaps and stalls.
// ----------------------------------------------------------------------------
module mlp_relu_inference_argmax_top_tb;
	import mlp_pkg::*;

	typedef struct {
		logic [1:0]         func;
		logic [1:0]         layer_index;
		logic [9:0]         row_index;
		logic [9:0]         col_index;
		logic signed [15:0] item_value;
		logic [9:0]         sample_label;
		logic               last_pixel;
	} beat_t;

	typedef struct {
		logic [9:0]  predicted_class;
		logic [14:0] max_score;
		logic        matches_label;
	} class_t;

	typedef struct {
		beat_t  b;
		bit     typed;
		class_t want;
	} dir_row_t;

	localparam int CFG_COUNT = 6;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_BITS-1:0] wr_index;
	logic [CFG_BITS-1:0] wr_data;

	mlp_in_if  in_ch ();
	mlp_out_if out_ch ();

	mlp_relu_inference_argmax_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (in_ch),
		.result   (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// predictor state
	int unsigned cfg_reg [CFG_COUNT];
	int          weight_mem [WEIGHT_WORDS];
	int          bias_mem [BIAS_DEPTH];
	int          pixel_mem [MAX_WIDTH];

	class_t      pending_q [$];
	int          errors = 0;
	int          n_results = 0;
	int          n_beats = 0;
	int          n_shapes = 0;
	bit          no_gaps = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int unsigned layer_width(int unsigned k);
		int unsigned v;
		if (k > 4)
			return 1;
		v = cfg_reg[1 + k];
		if (v < 1) v = 1;
		if (v > MAX_WIDTH) v = MAX_WIDTH;
		return v;
	endfunction

	function automatic int unsigned layers_active();
		int unsigned v;
		v = cfg_reg[0];
		if (v < 1) v = 1;
		if (v > MAX_LAYERS) v = MAX_LAYERS;
		return v;
	endfunction

	function automatic longint unsigned layer_base(int unsigned layer);
		longint unsigned base;
		base = 0;
		for (int unsigned k = 0; k < layer; k++)
			base += longint'(layer_width(k)) * layer_width(k + 1);
		return base;
	endfunction

	function automatic int relu_q411(longint s);
		logic signed [47:0] a;
		longint             q;
		a = s[47:0];
		if (a <= 0)
			return 0;
		q = (longint'(a) + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (q > 32767) q = 32767;
		return int'(q);
	endfunction

	function automatic class_t classify(logic [9:0] label);
		int              vec_in [MAX_WIDTH];
		int              vec_out [MAX_WIDTH];
		int unsigned     n_in, n_out, best;
		longint unsigned base, addr;
		longint          acc;
		int              w, best_val;
		class_t          res;
		for (int i = 0; i < MAX_WIDTH; i++)
			vec_in[i] = pixel_mem[i];
		for (int unsigned l = 0; l < layers_active(); l++) begin
			base = layer_base(l);
			n_in = layer_width(l);
			n_out = layer_width(l + 1);
			for (int unsigned r = 0; r < n_out; r++) begin
				acc = longint'(bias_mem[l * MAX_WIDTH + r]) <<< FRAC_BITS;
				for (int unsigned c = 0; c < n_in; c++) begin
					addr = base + longint'(r) * n_in + c;
					w = (addr < WEIGHT_WORDS) ? weight_mem[addr] : 0;
					acc += longint'(w) * longint'(vec_in[c]);
				end
				vec_out[r] = relu_q411(acc);
			end
			for (int unsigned r = 0; r < n_out; r++)
				vec_in[r] = vec_out[r];
		end
		best = 0;
		best_val = vec_in[0];
		for (int unsigned r = 1; r < layer_width(layers_active()); r++)
			if (vec_in[r] > best_val) begin
				best_val = vec_in[r];
				best = r;
			end
		res.predicted_class = best[9:0];
		res.max_score = best_val[14:0];
		res.matches_label = (best[9:0] == label);
		return res;
	endfunction

	// apply one accepted beat to the predictor state
	function automatic void apply_beat(beat_t b, bit typed, class_t want);
		int unsigned     L;
		longint unsigned addr;
		L = b.layer_index;
		case (b.func)
			FUNC_WEIGHT: begin
				if (b.row_index < layer_width(L + 1) && b.col_index < layer_width(L)) begin
					addr = layer_base(L) + longint'(b.row_index) * layer_width(L) + b.col_index;
					if (addr < WEIGHT_WORDS) weight_mem[addr] = b.item_value;
				end
			end
			FUNC_BIAS: begin
				if (b.row_index < layer_width(L + 1))
					bias_mem[L * MAX_WIDTH + b.row_index] = b.item_value;
			end
			FUNC_PIXEL: begin
				pixel_mem[b.col_index] = b.item_value;
				if (b.last_pixel)
					pending_q.insert(pending_q.size(), typed ? want : classify(b.sample_label));
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom_range(0, 1536) - 512);
		endcase
	endfunction

	function automatic beat_t mk(logic [1:0] f, int unsigned l, int unsigned r, int unsigned c,
			logic [15:0] v, int unsigned lab, bit last);
		beat_t b;
		b.func = f;
		b.layer_index = l[1:0];
		b.row_index = r[9:0];
		b.col_index = c[9:0];
		b.item_value = v;
		b.sample_label = lab[9:0];
		b.last_pixel = last;
		return b;
	endfunction

	task automatic send_beat(beat_t b, bit typed = 0, class_t want = '{default: '0});
		int g;
		g = pick_gap();
		repeat (g) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.func = b.func;
		in_ch.layer_index = b.layer_index;
		in_ch.row_index = b.row_index;
		in_ch.col_index = b.col_index;
		in_ch.item_value = b.item_value;
		in_ch.sample_label = b.sample_label;
		in_ch.last_pixel = b.last_pixel;
		do @(posedge clk); while (!in_ch.ready);
		apply_beat(b, typed, want);
		n_beats++;
	endtask

	// drain results, drop valid, let the block finish any load in flight
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = val[CFG_BITS-1:0];
		cfg_reg[idx] = (idx == CFG_LAYER_COUNT) ? (val & 32'h7) : (val & 32'h7FF);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic set_shape(int unsigned lc, int unsigned ins, int unsigned s1,
			int unsigned s2, int unsigned s3, int unsigned s4);
		write_reg(CFG_LAYER_COUNT, lc);
		write_reg(CFG_INPUT_SIZE, ins);
		write_reg(CFG_LAYER1_SIZE, s1);
		write_reg(CFG_LAYER2_SIZE, s2);
		write_reg(CFG_LAYER3_SIZE, s3);
		write_reg(CFG_LAYER4_SIZE, s4);
		n_shapes++;
	endtask

	// write every weight, bias and pixel the current shape reads, shuffled with noise
	task automatic load_network();
		beat_t q [$];
		beat_t tmp;
		int    j;
		for (int unsigned l = 0; l < layers_active(); l++) begin
			for (int unsigned r = 0; r < layer_width(l + 1); r++) begin
				q.insert(q.size(), mk(FUNC_BIAS, l, r, $urandom_range(0, 1023),
					pick_value(), 0, 0));
				for (int unsigned c = 0; c < layer_width(l); c++)
					q.insert(q.size(), mk(FUNC_WEIGHT, l, r, c, pick_value(), 0, 0));
			end
		end
		for (int unsigned c = 0; c < layer_width(0); c++)
			q.insert(q.size(), mk(FUNC_PIXEL, 0, 0, c, pick_value(), 0, 0));
		for (int i = q.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = q[i];
			q[i] = q[j];
			q[j] = tmp;
		end
		foreach (q[i]) begin
			if ($urandom_range(0, 19) == 0)
				send_beat(mk($urandom_range(0, 3) == 0 ? 2'd3 : 2'($urandom_range(0, 1)),
					$urandom_range(0, 3), $urandom_range(0, 1023), $urandom_range(0, 1023),
					16'($urandom), $urandom_range(0, 1023), $urandom_range(0, 1)));
			send_beat(q[i]);
		end
	endtask

	task automatic run_samples(int count);
		int unsigned nin, nout, lab;
		int          k;
		nin = layer_width(0);
		nout = layer_width(layers_active());
		repeat (count) begin
			k = $urandom_range(0, (nin < 4) ? nin : 4);
			repeat (k)
				send_beat(mk(FUNC_PIXEL, $urandom_range(0, 3), $urandom_range(0, 1023),
					$urandom_range(0, nin - 1), pick_value(), $urandom_range(0, 1023), 0));
			if ($urandom_range(0, 7) == 0)
				send_beat(mk(2'd3, 0, 0, 0, 16'($urandom), 0, 1));
			lab = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
				: $urandom_range(0, nout - 1);
			send_beat(mk(FUNC_PIXEL, $urandom_range(0, 3), $urandom_range(0, 1023),
				$urandom_range(0, nin - 1), pick_value(), lab, 1));
		end
	endtask

	// result side: random stalls, long ones now and then
	initial begin
		int  hold;
		bit  rdy;
		hold = 0;
		rdy = 1'b0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				rdy = ($urandom_range(0, 3) != 0);
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
			end
			out_ch.ready = rdy;
			hold--;
		end
	end

	always @(posedge clk) begin
		class_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_results++;
			if (pending_q.size() == 0) begin
				$error("unexpected result: class %0d score %0d", out_ch.predicted_class,
					out_ch.max_score);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (out_ch.predicted_class !== e.predicted_class) begin
					$error("predicted_class: expected %0d, got %0d", e.predicted_class,
						out_ch.predicted_class);
					errors++;
				end
				if (out_ch.max_score !== e.max_score) begin
					$error("max_score: expected %0d, got %0d", e.max_score, out_ch.max_score);
					errors++;
				end
				if (out_ch.matches_label !== e.matches_label) begin
					$error("matches_label: expected %0d, got %0d", e.matches_label,
						out_ch.matches_label);
					errors++;
				end
			end
		end
	end

	initial begin
		dir_row_t dir [$];
		int unsigned lc, sz [5];
		cfg_reg = '{2, 784, 128, 10, 10, 10};
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_WEIGHT;
		in_ch.layer_index = '0;
		in_ch.row_index = '0;
		in_ch.col_index = '0;
		in_ch.item_value = '0;
		in_ch.sample_label = '0;
		in_ch.last_pixel = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(posedge clk);

		// one neuron, one input: results read straight off the Q4.11 math
		set_shape(1, 1, 1, 1, 1, 1);
		dir.insert(dir.size(), '{mk(FUNC_WEIGHT, 0, 0, 0, 16'h0800, 0, 0), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(FUNC_BIAS, 0, 0, 0, 16'h0000, 0, 0), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(FUNC_PIXEL, 0, 0, 0, 16'h0800, 0, 1), 1, '{0, 2048, 1}});
		dir.insert(dir.size(), '{mk(FUNC_WEIGHT, 0, 0, 0, 16'h7FFF, 0, 1), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(FUNC_BIAS, 0, 0, 0, 16'h7FFF, 0, 0), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(FUNC_PIXEL, 0, 0, 0, 16'h7FFF, 1, 1), 1, '{0, 32767, 0}});
		dir.insert(dir.size(), '{mk(FUNC_BIAS, 3, 0, 0, 16'h0000, 0, 0), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(FUNC_BIAS, 0, 0, 0, 16'h0000, 0, 0), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(FUNC_WEIGHT, 0, 0, 0, 16'h8000, 0, 0), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(FUNC_PIXEL, 0, 0, 0, 16'h7FFF, 0, 1), 1, '{0, 0, 1}});
		dir.insert(dir.size(), '{mk(FUNC_WEIGHT, 0, 0, 0, 16'h0001, 0, 0), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(FUNC_PIXEL, 0, 0, 0, 16'h0400, 1023, 1), 1, '{0, 1, 0}});
		dir.insert(dir.size(), '{mk(FUNC_PIXEL, 0, 0, 0, 16'h03FF, 0, 1), 1, '{0, 0, 1}});
		// ignored: out of range row and column, unused code, pixel beyond the input size
		dir.insert(dir.size(), '{mk(FUNC_WEIGHT, 0, 1023, 0, 16'h7FFF, 0, 0), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(FUNC_WEIGHT, 0, 0, 1023, 16'h7FFF, 0, 0), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(FUNC_BIAS, 0, 1023, 0, 16'h7FFF, 0, 0), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(2'd3, 3, 1023, 1023, 16'hFFFF, 1023, 1), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(FUNC_PIXEL, 0, 0, 1023, 16'h7FFF, 0, 0), 0, '{0, 0, 0}});
		dir.insert(dir.size(), '{mk(FUNC_PIXEL, 3, 1023, 0, 16'h0400, 0, 1), 1, '{0, 1, 1}});
		foreach (dir[i])
			send_beat(dir[i].b, dir[i].typed, dir[i].want);
		wait_idle();

		// zero layer count and sizes clamp to one; an oversize count clamps to four
		set_shape(0, 3, 0, 1, 1, 1);
		load_network();
		run_samples(4);
		wait_idle();
		set_shape(7, 0, 2, 1, 0, 3);
		load_network();
		run_samples(4);
		wait_idle();

		repeat (4) begin
			lc = $urandom_range(1, 4);
			foreach (sz[k])
				sz[k] = $urandom_range(1, 8);
			no_gaps = ($urandom_range(0, 3) == 0);
			set_shape(lc, sz[0], sz[1], sz[2], sz[3], sz[4]);
			load_network();
			run_samples(15);
			wait_idle();
		end

		$display("Covered %0d network shapes, %0d input beats, %0d classifications checked.",
			n_shapes, n_beats, n_results);
		if (errors == 0 && pending_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
